/* hdl/dsp_program_sequencer_loop_stack_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the program sequencer checker.
// ----------------------------------------------------------------------------
`ifndef DSP_PROGRAM_SEQUENCER_LOOP_STACK_MACROS_SVH
`define DSP_PROGRAM_SEQUENCER_LOOP_STACK_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define DPSLS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sequencer assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define DPSLS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sequencer assertion failed");

`endif

/* hdl/dpsls_pkg.sv */
// ----------------------------------------------------------------------------
// dpsls_pkg
// Types, codes and the condition evaluator of the DSP program sequencer.
// ----------------------------------------------------------------------------
package dpsls_pkg;

    localparam int PC_W    = 16;
    localparam int COUNT_W = 16;

    // Control actions of a retired instruction.
    localparam logic [3:0] ACT_ADVANCE    = 4'd0;
    localparam logic [3:0] ACT_JUMP_CC    = 4'd1;
    localparam logic [3:0] ACT_CALL_CC    = 4'd2;
    localparam logic [3:0] ACT_RET_CC     = 4'd3;
    localparam logic [3:0] ACT_IF_CC      = 4'd4;
    localparam logic [3:0] ACT_CALL_REG   = 4'd5;
    localparam logic [3:0] ACT_JUMP_REG   = 4'd6;
    localparam logic [3:0] ACT_LOOP       = 4'd7;
    localparam logic [3:0] ACT_BLOCK_LOOP = 4'd8;

    // Condition codes.
    localparam logic [3:0] CC_GE      = 4'd0;
    localparam logic [3:0] CC_L       = 4'd1;
    localparam logic [3:0] CC_G       = 4'd2;
    localparam logic [3:0] CC_LE      = 4'd3;
    localparam logic [3:0] CC_NE      = 4'd4;
    localparam logic [3:0] CC_EQ      = 4'd5;
    localparam logic [3:0] CC_NC      = 4'd6;
    localparam logic [3:0] CC_C       = 4'd7;
    localparam logic [3:0] CC_BELOW32 = 4'd8;
    localparam logic [3:0] CC_ABOVE32 = 4'd9;
    localparam logic [3:0] CC_NOK     = 4'd10;
    localparam logic [3:0] CC_OK      = 4'd11;
    localparam logic [3:0] CC_O       = 4'd12;
    localparam logic [3:0] CC_ALWAYS  = 4'd13;

    typedef struct packed {
        logic [3:0]         action;
        logic [3:0]         condition;
        logic [PC_W-1:0]    target_address;
        logic [PC_W-1:0]    loop_end_address;
        logic [COUNT_W-1:0] loop_count;
        logic [1:0]         instr_words;
        logic               flag_sign;
        logic               flag_overflow;
        logic               flag_zero;
        logic               flag_carry;
        logic               flag_above_s32;
        logic               flag_ok;
    } cmd_t;

    typedef struct packed {
        logic [PC_W-1:0] next_pc;
        logic            condition_met;
        logic            loop_taken;
        logic            stack_fault;
    } res_t;

    // Stack control bundle.
    typedef struct packed {
        logic push;
        logic pop;
        logic wr_top;
    } lifo_ctl_t;

    function automatic logic eval_cond(input cmd_t c);
        logic s_eq_o;
        logic met;
        s_eq_o = (c.flag_sign == c.flag_overflow);
        unique case (c.condition)
            CC_GE:      met = s_eq_o;
            CC_L:       met = !s_eq_o;
            CC_G:       met = s_eq_o && !c.flag_zero;
            CC_LE:      met = !s_eq_o || c.flag_zero;
            CC_NE:      met = !c.flag_zero;
            CC_EQ:      met = c.flag_zero;
            CC_NC:      met = !c.flag_carry;
            CC_C:       met = c.flag_carry;
            CC_BELOW32: met = !c.flag_above_s32;
            CC_ABOVE32: met = c.flag_above_s32;
            CC_NOK:     met = !c.flag_ok;
            CC_OK:      met = c.flag_ok;
            CC_O:       met = c.flag_overflow;
            CC_ALWAYS:  met = 1'b1;
            default:    met = 1'b0;
        endcase
        return met;
    endfunction

endpackage

/* hdl/dsp_program_sequencer_loop_stack.sv */
// ----------------------------------------------------------------------------
// dsp_program_sequencer_loop_stack
// Program counter sequencer with call stack and hardware loop stack.
// ----------------------------------------------------------------------------
// Usage: each item on the cmd channel is one retired instruction with its
// condition code, target, loop operands and status flags. An item is taken
// at a rising edge with cmd_valid high and cmd_stall low. The block then
// updates its program counter and stacks and returns one item on the res
// channel: the new program counter, the condition outcome, whether a loop
// branched back, and a stack fault flag.
// Operation: an item is first captured in the item register, then the
// sequencer's execute state computes it. For an advancing instruction
// the end-of-loop check pops one exhausted loop per sequencer step before
// the final step. cmd_stall stays high while an item is at work, so a
// new item is taken only once the last one is through. A finished result
// sits in an output register; a new item can be taken while it waits.
// If the receiver stalls, the next item's final step waits until the
// output register frees up, and the stacks do not move.
// Reset clears the program counter, both stack levels and the output
// valid; stack contents are not cleared since they are read only below
// the level.
// ----------------------------------------------------------------------------
module dsp_program_sequencer_loop_stack #(
    parameter int CALL_STACK_DEPTH = 8,
    parameter int LOOP_STACK_DEPTH = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_stall,
    input  dpsls_pkg::cmd_t cmd,
    output logic            res_valid,
    input  logic            res_stall,
    output dpsls_pkg::res_t res
);
    import dpsls_pkg::*;

    // Sequencer states, one-hot.
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    localparam int LOOP_W = PC_W + COUNT_W;

    state_t            state_reg;
    state_t            state_next;
    cmd_t              item_reg;
    logic [PC_W-1:0]   pc_reg;
    logic [PC_W-1:0]   pc_next;
    logic              res_valid_reg;
    logic              res_valid_next;
    res_t              res_reg;

    logic              accept;
    logic              out_free;
    logic              met;
    logic              done;
    logic              commit;
    logic              fault;
    logic              taken;
    logic [PC_W-1:0]   npc;

    // The shared adder: program counter plus a selected increment.
    logic [PC_W-1:0]   inc;
    logic [PC_W-1:0]   pc_sum;

    lifo_ctl_t         cs_req;
    lifo_ctl_t         ls_req;
    lifo_ctl_t         cs_ctl;
    lifo_ctl_t         ls_ctl;
    logic [PC_W-1:0]   cs_top;
    logic              cs_empty;
    logic              cs_full;
    logic [LOOP_W-1:0] ls_top;
    logic [LOOP_W-1:0] ls_wdata;
    logic              ls_empty;
    logic              ls_full;
    logic [PC_W-1:0]   ls_end;
    logic [COUNT_W-1:0] ls_count;

    assign accept    = cmd_valid && !cmd_stall;
    assign cmd_stall = (state_reg != S_IDLE);
    assign out_free  = !res_valid_reg || !res_stall;
    assign met       = eval_cond(item_reg);
    assign pc_sum    = pc_reg + inc;
    assign ls_end    = ls_top[LOOP_W-1:COUNT_W];
    assign ls_count  = ls_top[COUNT_W-1:0];

    // A step that finishes the item waits for room in the output register;
    // a loop pop step never waits.
    assign commit = (state_reg == S_EXEC) && (!done || out_free);
    assign cs_ctl = commit ? cs_req : '0;
    assign ls_ctl = commit ? ls_req : '0;

    always_comb
    begin
        done     = 1'b1;
        fault    = 1'b0;
        taken    = 1'b0;
        inc      = PC_W'(1);
        npc      = pc_sum;
        cs_req   = '0;
        ls_req   = '0;
        ls_wdata = {item_reg.loop_end_address, item_reg.loop_count};
        unique case (item_reg.action)
            ACT_JUMP_CC:
            begin
                inc = PC_W'(2);
                npc = met ? item_reg.target_address : pc_sum;
            end
            ACT_CALL_CC:
            begin
                inc = PC_W'(2);
                if (met)
                begin
                    if (cs_full)
                    begin
                        fault = 1'b1;
                    end
                    else
                    begin
                        cs_req.push = 1'b1;
                        npc         = item_reg.target_address;
                    end
                end
            end
            ACT_RET_CC:
            begin
                if (met && !cs_empty)
                begin
                    cs_req.pop = 1'b1;
                    npc        = cs_top;
                end
                else
                begin
                    fault = met;
                end
            end
            ACT_IF_CC:
            begin
                inc = met ? PC_W'(1) : PC_W'(2);
            end
            ACT_CALL_REG:
            begin
                if (cs_full)
                begin
                    fault = 1'b1;
                end
                else
                begin
                    cs_req.push = 1'b1;
                    npc         = item_reg.target_address;
                end
            end
            ACT_JUMP_REG:
            begin
                npc = item_reg.target_address;
            end
            ACT_LOOP:
            begin
                // Single-instruction loop: start and end are both the next word.
                ls_wdata = {pc_sum, item_reg.loop_count};
                if (cs_full || ls_full)
                begin
                    fault = 1'b1;
                end
                else
                begin
                    cs_req.push = 1'b1;
                    ls_req.push = 1'b1;
                end
            end
            ACT_BLOCK_LOOP:
            begin
                inc = PC_W'(2);
                if (cs_full || ls_full)
                begin
                    fault = 1'b1;
                end
                else
                begin
                    cs_req.push = 1'b1;
                    ls_req.push = 1'b1;
                end
            end
            default:
            begin
                // Advance and unused actions run the end-of-loop check.
                inc = PC_W'(item_reg.instr_words);
                if (!ls_empty)
                begin
                    if (cs_empty)
                    begin
                        fault = 1'b1;
                    end
                    else if (ls_count != '0)
                    begin
                        if (pc_reg == ls_end)
                        begin
                            npc           = cs_top;
                            taken         = 1'b1;
                            ls_wdata      = {ls_end, ls_count - COUNT_W'(1)};
                            ls_req.wr_top = 1'b1;
                        end
                    end
                    else
                    begin
                        // Exhausted loop: drop it and look at the next one.
                        done       = 1'b0;
                        cs_req.pop = 1'b1;
                        ls_req.pop = 1'b1;
                    end
                end
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        pc_next        = pc_reg;
        res_valid_next = res_valid_reg && res_stall;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (commit && done)
                begin
                    state_next     = S_IDLE;
                    pc_next        = npc;
                    res_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pc_reg        <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= cmd;
        end
        if (commit && done)
        begin
            res_reg.next_pc       <= npc;
            res_reg.condition_met <= met;
            res_reg.loop_taken    <= taken;
            res_reg.stack_fault   <= fault;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // Call stack: return addresses and loop start addresses.
    dpsls_lifo #(
        .WIDTH (PC_W),
        .DEPTH (CALL_STACK_DEPTH)
    ) u_call_stack (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (cs_ctl),
        .wdata (pc_sum),
        .top   (cs_top),
        .empty (cs_empty),
        .full  (cs_full)
    );

    // Loop stack: loop end address and remaining count per active loop.
    dpsls_lifo #(
        .WIDTH (LOOP_W),
        .DEPTH (LOOP_STACK_DEPTH)
    ) u_loop_stack (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ls_ctl),
        .wdata (ls_wdata),
        .top   (ls_top),
        .empty (ls_empty),
        .full  (ls_full)
    );

endmodule

/* hdl/dpsls_lifo.sv */
// ----------------------------------------------------------------------------
// dpsls_lifo
// Register-based stack with push, pop and top rewrite; reports empty and full.
// ----------------------------------------------------------------------------
module dpsls_lifo #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dpsls_pkg::lifo_ctl_t ctl,
    input  logic [WIDTH-1:0]     wdata,
    output logic [WIDTH-1:0]     top,
    output logic                 empty,
    output logic                 full
);
    import dpsls_pkg::*;

    localparam int LW = $clog2(DEPTH + 1);
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [LW-1:0]    level_reg;
    logic [LW-1:0]    level_next;
    logic [LW-1:0]    level_dec;
    logic [IW-1:0]    top_idx;
    logic [WIDTH-1:0] mem [DEPTH];

    assign empty     = (level_reg == '0);
    assign full      = (level_reg == LW'(DEPTH));
    assign level_dec = level_reg - LW'(1);
    assign top_idx   = empty ? '0 : level_dec[IW-1:0];
    assign top       = mem[top_idx];

    always_comb
    begin
        priority if (ctl.push && !full)
        begin
            level_next = level_reg + LW'(1);
        end
        else if (ctl.pop && !empty)
        begin
            level_next = level_dec;
        end
        else
        begin
            level_next = level_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= '0;
        end
        else
        begin
            level_reg <= level_next;
        end
    end

    // A push takes precedence over a rewrite of the top entry.
    always_ff @(posedge clk)
    begin
        if (ctl.push && !full)
        begin
            mem[level_reg[IW-1:0]] <= wdata;
        end
        else if (ctl.wr_top && !empty)
        begin
            mem[top_idx] <= wdata;
        end
    end

endmodule

/* hdl/dpsls_checker.sv */
// ----------------------------------------------------------------------------
// dpsls_checker
// Port-level checks of the program sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`include "dsp_program_sequencer_loop_stack_macros.svh"

module dpsls_checker (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    input  logic            cmd_stall,
    input  logic            res_valid,
    input  logic            res_stall,
    input  dpsls_pkg::res_t res
);
    import dpsls_pkg::*;

    logic cmd_take;
    logic res_held;

    assign cmd_take = cmd_valid && !cmd_stall;
    assign res_held = res_valid && res_stall;

    // A stalled result stays offered and unchanged.
    `DPSLS_ASSERT_NEXT(a_res_valid_hold, clk, rst_n, res_held, res_valid)
    `DPSLS_ASSERT_NEXT(a_res_data_hold, clk, rst_n, res_held, $stable(res))

    // Once an item is taken, the block is busy in the following cycle.
    `DPSLS_ASSERT_NEXT(a_busy_after_take, clk, rst_n, cmd_take, cmd_stall)

    // A new result appears exactly as the sequencer returns to idle.
    `DPSLS_ASSERT_NOW(a_idle_on_result, clk, rst_n, $rose(res_valid), !cmd_stall)

endmodule

bind dsp_program_sequencer_loop_stack dpsls_checker u_dpsls_checker (.*);

/* sim/dsp_program_sequencer_loop_stack_scoreboard.sv */
// ----------------------------------------------------------------------------
// dsp_program_sequencer_loop_stack_scoreboard
// Watches both channels of the program sequencer. It keeps its own copy of
// the program counter and the stacks, predicts each result and compares.
// ----------------------------------------------------------------------------
module dsp_program_sequencer_loop_stack_scoreboard #(
    parameter int CALL_STACK_DEPTH = 8,
    parameter int LOOP_STACK_DEPTH = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    input  logic            cmd_stall,
    input  dpsls_pkg::cmd_t cmd,
    input  logic            res_valid,
    input  logic            res_stall,
    input  dpsls_pkg::res_t res,
    output int unsigned     fail_count,
    output int unsigned     pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import dpsls_pkg::*;

    // Shadow of the sequencer state.
    logic [PC_W-1:0]    pc_shadow;
    logic [PC_W-1:0]    call_entries [CALL_STACK_DEPTH];
    logic [PC_W-1:0]    loop_ends    [LOOP_STACK_DEPTH];
    logic [COUNT_W-1:0] loop_counts  [LOOP_STACK_DEPTH];
    int                 call_depth;
    int                 loop_depth;

    res_t        pc_results_due [$];
    int unsigned mismatch_total = 0;
    int unsigned results_due    = 0;

    assign fail_count    = mismatch_total;
    assign pending_count = results_due;

    task automatic flag_mismatch(input string what, input logic [15:0] want,
                                 input logic [15:0] got);
        $display("%0t: %s: expected %h, got %h", $time, what, want, got);
        mismatch_total++;
    endtask

    function automatic logic condition_holds(input cmd_t c);
        logic less;
        logic holds;
        less = c.flag_sign ^ c.flag_overflow;
        case (c.condition)
            CC_GE:      holds = !less;
            CC_L:       holds = less;
            CC_G:       holds = !less && !c.flag_zero;
            CC_LE:      holds = less || c.flag_zero;
            CC_NE:      holds = !c.flag_zero;
            CC_EQ:      holds = c.flag_zero;
            CC_NC:      holds = !c.flag_carry;
            CC_C:       holds = c.flag_carry;
            CC_BELOW32: holds = !c.flag_above_s32;
            CC_ABOVE32: holds = c.flag_above_s32;
            CC_NOK:     holds = !c.flag_ok;
            CC_OK:      holds = c.flag_ok;
            CC_O:       holds = c.flag_overflow;
            CC_ALWAYS:  holds = 1'b1;
            default:    holds = 1'b0;
        endcase
        return holds;
    endfunction

    task automatic push_return(input logic [PC_W-1:0] addr, output logic pushed);
        pushed = (call_depth < CALL_STACK_DEPTH);
        if (pushed)
        begin
            call_entries[call_depth] = addr;
            call_depth++;
        end
    endtask

    task automatic open_loop(input logic [PC_W-1:0] start, input logic [PC_W-1:0] last,
                             input logic [COUNT_W-1:0] count, inout logic fault);
        if (call_depth >= CALL_STACK_DEPTH || loop_depth >= LOOP_STACK_DEPTH)
        begin
            fault = 1'b1;
        end
        else
        begin
            call_entries[call_depth] = start;
            call_depth++;
            loop_ends[loop_depth]   = last;
            loop_counts[loop_depth] = count;
            loop_depth++;
        end
    endtask

    // Applies one retired instruction to the shadow state and returns the
    // result the sequencer must produce for it.
    task automatic retire_instruction(input cmd_t c, output res_t r);
        logic            met;
        logic            fault;
        logic            taken;
        logic            pushed;
        logic            settled;
        logic [PC_W-1:0] pc_plus1;
        logic [PC_W-1:0] pc_plus2;
        met      = condition_holds(c);
        fault    = 1'b0;
        taken    = 1'b0;
        pc_plus1 = pc_shadow + 16'd1;
        pc_plus2 = pc_shadow + 16'd2;
        case (c.action)
            ACT_JUMP_CC:
                pc_shadow = met ? c.target_address : pc_plus2;
            ACT_CALL_CC:
            begin
                pc_shadow = pc_plus2;
                if (met)
                begin
                    push_return(pc_plus2, pushed);
                    if (pushed)
                        pc_shadow = c.target_address;
                    else
                        fault = 1'b1;
                end
            end
            ACT_RET_CC:
            begin
                if (met && call_depth > 0)
                begin
                    call_depth--;
                    pc_shadow = call_entries[call_depth];
                end
                else
                begin
                    fault     = met;
                    pc_shadow = pc_plus1;
                end
            end
            ACT_IF_CC:
                pc_shadow = met ? pc_plus1 : pc_plus2;
            ACT_CALL_REG:
            begin
                push_return(pc_plus1, pushed);
                pc_shadow = pushed ? c.target_address : pc_plus1;
                fault     = !pushed;
            end
            ACT_JUMP_REG:
                pc_shadow = c.target_address;
            ACT_LOOP:
            begin
                open_loop(pc_plus1, pc_plus1, c.loop_count, fault);
                pc_shadow = pc_plus1;
            end
            ACT_BLOCK_LOOP:
            begin
                open_loop(pc_plus2, c.loop_end_address, c.loop_count, fault);
                pc_shadow = pc_plus2;
            end
            default:
            begin
                // End-of-loop check: drop exhausted loops, then maybe branch back.
                settled = 1'b0;
                while (!settled && loop_depth > 0)
                begin
                    if (call_depth == 0)
                    begin
                        fault   = 1'b1;
                        settled = 1'b1;
                    end
                    else if (loop_counts[loop_depth-1] != '0)
                    begin
                        if (pc_shadow == loop_ends[loop_depth-1])
                        begin
                            pc_shadow = call_entries[call_depth-1];
                            loop_counts[loop_depth-1] = loop_counts[loop_depth-1] - 16'd1;
                            taken = 1'b1;
                        end
                        settled = 1'b1;
                    end
                    else
                    begin
                        call_depth--;
                        loop_depth--;
                    end
                end
                if (!taken)
                    pc_shadow = pc_shadow + 16'(c.instr_words);
            end
        endcase
        r.next_pc       = pc_shadow;
        r.condition_met = met;
        r.loop_taken    = taken;
        r.stack_fault   = fault;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        res_t due;
        res_t predicted;
        if (!rst_n)
        begin
            pc_shadow  = '0;
            call_depth = 0;
            loop_depth = 0;
            pc_results_due.delete();
            results_due = 0;
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                if (pc_results_due.size() == 0)
                begin
                    flag_mismatch("result with none expected", '0, res.next_pc);
                end
                else
                begin
                    due = pc_results_due.pop_front();
                    if (res.next_pc !== due.next_pc)
                        flag_mismatch("next_pc", due.next_pc, res.next_pc);
                    if (res.condition_met !== due.condition_met)
                        flag_mismatch("condition_met", 16'(due.condition_met),
                                      16'(res.condition_met));
                    if (res.loop_taken !== due.loop_taken)
                        flag_mismatch("loop_taken", 16'(due.loop_taken),
                                      16'(res.loop_taken));
                    if (res.stack_fault !== due.stack_fault)
                        flag_mismatch("stack_fault", 16'(due.stack_fault),
                                      16'(res.stack_fault));
                end
            end
            if (cmd_valid && !cmd_stall)
            begin
                retire_instruction(cmd, predicted);
                pc_results_due = {pc_results_due, predicted};
            end
            results_due = pc_results_due.size();
        end
    end

endmodule

/* sim/tb_dsp_program_sequencer_loop_stack.sv */
// ----------------------------------------------------------------------------
// tb_dsp_program_sequencer_loop_stack
// Drives retired instructions into the program sequencer and gives the
// verdict. A directed opening fills and empties both stacks, then random
// loop bodies, nested loops, call/return pairs and noise follow, then loops with large counts.
// ----------------------------------------------------------------------------
module tb_dsp_program_sequencer_loop_stack;
    timeunit 1ns;
    timeprecision 1ps;

    import dpsls_pkg::*;

    localparam int CALL_DEPTH   = 8;
    localparam int LOOP_DEPTH   = 4;
    localparam int RANDOM_ITEMS = 700;
    localparam int HOLD_CYCLES  = 150;
    localparam int HOLD_AFTER   = 300;
    // Every item at its slowest (sender gap, all loop pops, receiver stall)
    // stays far below this limit, so it leaves a wide margin.
    localparam int unsigned CYCLE_LIMIT = 400000;

    // Action and condition codes the sequencer does not define. Unused
    // actions behave like an advance; unused conditions are never met.
    localparam logic [3:0] ACT_UNUSED_LO = ACT_BLOCK_LOOP + 4'd1;
    localparam logic [3:0] ACT_UNUSED_HI = 4'hF;
    localparam logic [3:0] CC_UNUSED_LO  = CC_ALWAYS + 4'd1;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic cmd_valid = 1'b0;
    logic res_stall = 1'b0;
    cmd_t cmd       = '0;
    logic cmd_stall;
    logic res_valid;
    res_t res;

    int unsigned fail_count;
    int unsigned pending;
    int unsigned items_sent  = 0;
    int unsigned cycle_count = 0;
    int          burst_left  = 0;

    dsp_program_sequencer_loop_stack #(
        .CALL_STACK_DEPTH(CALL_DEPTH),
        .LOOP_STACK_DEPTH(LOOP_DEPTH)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    dsp_program_sequencer_loop_stack_scoreboard #(
        .CALL_STACK_DEPTH(CALL_DEPTH),
        .LOOP_STACK_DEPTH(LOOP_DEPTH)
    ) pc_scoreboard (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd_stall     (cmd_stall),
        .cmd           (cmd),
        .res_valid     (res_valid),
        .res_stall     (res_stall),
        .res           (res),
        .fail_count    (fail_count),
        .pending_count (pending)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("dsp_program_sequencer_loop_stack test failed");
            $finish;
        end
    end

    // An instruction with random condition, flags and addresses. It is one
    // word long and carries a zero loop count, so that a loop it opens is
    // dropped by the next advance instead of lingering on the stacks.
    function automatic cmd_t base_item(input logic [3:0] act);
        cmd_t c;
        c.action           = act;
        c.condition        = 4'($urandom_range(0, 15));
        c.target_address   = 16'($urandom);
        c.loop_end_address = 16'($urandom);
        c.loop_count       = '0;
        c.instr_words      = 2'd1;
        c.flag_sign        = 1'($urandom);
        c.flag_overflow    = 1'($urandom);
        c.flag_zero        = 1'($urandom);
        c.flag_carry       = 1'($urandom);
        c.flag_above_s32   = 1'($urandom);
        c.flag_ok          = 1'($urandom);
        return c;
    endfunction

    // Presents one item and holds it until the sequencer takes it. The
    // sender works in bursts: when a burst runs out, valid drops for a random
    // gap and a new burst length is drawn, sometimes a long one so that
    // stretches without gaps occur as well.
    task automatic offer(input cmd_t c);
        cmd       <= c;
        cmd_valid <= 1'b1;
        do
            @(posedge clk);
        while (cmd_stall);
        items_sent++;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 50)
                                                     : $urandom_range(0, 8);
        end
    endtask

    // Receiver: runs of free flow, of random stalls at a few densities, and
    // of a fixed two-in-five pattern. Once, well into the run, it holds off
    // for a long stretch while the sender keeps offering, so the output
    // register fills and the sequencer has to stall its input.
    initial
    begin : receiver
        int  run_len;
        int  stall_pct;
        bit  patterned;
        bit  held = 1'b0;
        wait (rst_n);
        forever
        begin
            if (!held && items_sent >= HOLD_AFTER)
            begin
                held = 1'b1;
                res_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                patterned = ($urandom_range(0, 3) == 0);
                stall_pct = $urandom_range(0, 2) * 25;
                run_len   = $urandom_range(8, 64);
                for (int k = 0; k < run_len; k++)
                begin
                    if (patterned)
                        res_stall <= (k % 5 < 2);
                    else
                        res_stall <= ($urandom_range(0, 99) < stall_pct);
                    @(posedge clk);
                end
            end
        end
    end

    initial
    begin : stimulus
        cmd_t        c;
        logic [15:0] base_addr;
        int          body_len;
        int          outer_reps;
        int          inner_reps;
        int unsigned random_start;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // ---------------------------------------------------------------
        // Directed opening.
        // ---------------------------------------------------------------
        // Advance by zero words with every flag low, then by three words
        // with every flag high.
        c = base_item(ACT_ADVANCE);
        c.instr_words = 2'd0;
        c.condition   = CC_GE;
        {c.flag_sign, c.flag_overflow, c.flag_zero,
         c.flag_carry, c.flag_above_s32, c.flag_ok} = 6'b000000;
        offer(c);
        c = base_item(ACT_ADVANCE);
        c.instr_words = 2'd3;
        c.condition   = CC_LE;
        {c.flag_sign, c.flag_overflow, c.flag_zero,
         c.flag_carry, c.flag_above_s32, c.flag_ok} = 6'b111111;
        offer(c);

        // A taken return with nothing on the call stack faults.
        c = base_item(ACT_RET_CC);
        c.condition = CC_ALWAYS;
        offer(c);

        // Jump to the top of the address space, then skip forward across
        // the wrap, once with the condition met and once with an unused one.
        c = base_item(ACT_JUMP_CC);
        c.condition      = CC_ALWAYS;
        c.target_address = 16'hFFFF;
        offer(c);
        c = base_item(ACT_IF_CC);
        c.condition = CC_EQ;
        c.flag_zero = 1'b1;
        offer(c);
        c = base_item(ACT_IF_CC);
        c.condition = CC_UNUSED_LO;
        offer(c);
        c = base_item(ACT_JUMP_REG);
        c.target_address = '0;
        offer(c);

        // Fill the loop stack with exhausted loops; one more loop faults.
        repeat (LOOP_DEPTH) offer(base_item(ACT_LOOP));
        offer(base_item(ACT_BLOCK_LOOP));

        // Fill the rest of the call stack; one more call faults.
        repeat (CALL_DEPTH - LOOP_DEPTH) offer(base_item(ACT_CALL_REG));
        c = base_item(ACT_CALL_CC);
        c.condition = CC_ALWAYS;
        offer(c);

        // Return from the calls, leaving only loop starts on the call
        // stack. The next advance then drops every exhausted loop at once.
        c = base_item(ACT_RET_CC);
        c.condition = CC_ALWAYS;
        repeat (CALL_DEPTH - LOOP_DEPTH) offer(c);
        offer(base_item(ACT_UNUSED_HI));

        // A return takes away the start of an open loop, so the loop check
        // finds the call stack empty and faults.
        offer(base_item(ACT_LOOP));
        offer(c);
        offer(base_item(ACT_ADVANCE));

        // ---------------------------------------------------------------
        // Random part: mostly well-formed loop and call sequences.
        // ---------------------------------------------------------------
        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2:
                begin
                    // Block loop of one to four words, run to completion.
                    base_addr  = 16'($urandom);
                    body_len   = $urandom_range(1, 4);
                    outer_reps = $urandom_range(0, 3);
                    c = base_item(ACT_JUMP_REG);
                    c.target_address = base_addr;
                    offer(c);
                    c = base_item(ACT_BLOCK_LOOP);
                    c.loop_end_address = base_addr + 16'(body_len + 1);
                    c.loop_count       = 16'(outer_reps);
                    offer(c);
                    repeat (body_len * (outer_reps + 1))
                    begin
                        if ($urandom_range(0, 7) == 0)
                            offer(base_item(4'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI))));
                        else
                            offer(base_item(ACT_ADVANCE));
                    end
                end
                3, 4:
                begin
                    // Three-word block loop whose first word opens a
                    // single-instruction loop on the second. When both run
                    // out together, one advance drops both.
                    base_addr  = 16'($urandom);
                    outer_reps = $urandom_range(0, 2);
                    c = base_item(ACT_JUMP_REG);
                    c.target_address = base_addr;
                    offer(c);
                    c = base_item(ACT_BLOCK_LOOP);
                    c.loop_end_address = base_addr + 16'd4;
                    c.loop_count       = 16'(outer_reps);
                    offer(c);
                    repeat (outer_reps + 1)
                    begin
                        inner_reps = $urandom_range(0, 3);
                        c = base_item(ACT_LOOP);
                        c.loop_count = 16'(inner_reps);
                        offer(c);
                        repeat (inner_reps + 2) offer(base_item(ACT_ADVANCE));
                    end
                end
                5, 6:
                begin
                    // Call, a short body of any sizes, and return.
                    c = base_item($urandom_range(0, 1) ? ACT_CALL_CC : ACT_CALL_REG);
                    c.condition = CC_ALWAYS;
                    offer(c);
                    repeat ($urandom_range(0, 3))
                    begin
                        c = base_item(ACT_ADVANCE);
                        c.instr_words = 2'($urandom_range(0, 3));
                        offer(c);
                    end
                    c = base_item(ACT_RET_CC);
                    c.condition = CC_ALWAYS;
                    offer(c);
                end
                default:
                begin
                    // Noise: any action, condition and size.
                    repeat ($urandom_range(1, 4))
                    begin
                        c = base_item(4'($urandom_range(0, 15)));
                        c.instr_words = 2'($urandom_range(0, 3));
                        offer(c);
                    end
                end
            endcase
        end

        // ---------------------------------------------------------------
        // Closing: loops with large counts. These stay on the stacks, so
        // they come last.
        // ---------------------------------------------------------------
        c = base_item(ACT_JUMP_REG);
        c.target_address = 16'hFFFE;
        offer(c);
        c = base_item(ACT_BLOCK_LOOP);
        c.loop_end_address = 16'h0000;
        c.loop_count       = 16'hFFFF;
        offer(c);
        repeat (2) offer(base_item(ACT_ADVANCE));
        c = base_item(ACT_LOOP);
        c.loop_count = 16'hAAAA;
        offer(c);
        repeat (2) offer(base_item(ACT_ADVANCE));

        // Drain: wait for every predicted result, then wait on for any stray
        // result to show up.
        cmd_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (2 * LOOP_DEPTH + 8) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("dsp_program_sequencer_loop_stack test passed");
        else
            $display("dsp_program_sequencer_loop_stack test failed");
        $finish;
    end

endmodule
